// ===== hdl/rc3_pkg.sv =====
`timescale 1ns / 1ps
// types and constants shared by the 3x3 rgb convolution block
// no dependencies
package rc3_pkg;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned NUM_W   = 20;
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned KROW_W  = 24;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;
  localparam logic [IDX_W-1:0] REG_KERNEL_DIV    = 3'd5;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic               run_last;
  } pix_out_t;

  // window tap k is row k/3 (top first), column k%3 (left first)
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic               int_v;
    logic               bord_v;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   px;
    win_t               win;
  } entry_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } geom_t;

  typedef struct packed {
    logic [KROW_W-1:0] row_top;
    logic [KROW_W-1:0] row_middle;
    logic [KROW_W-1:0] row_bottom;
    logic [DIV_W-1:0]  divisor;
  } kern_t;

endpackage

// ===== hdl/rgb_convolution_3x3.sv =====
`timescale 1ns / 1ps
// top level of the streaming 3x3 rgb convolution filter
// depends on rc3_pkg, rc3_front, rc3_queue, rc3_back
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  in_      | in_valid/in_stall  | pix_in_t  (rgb + frame_start)
//  out_     | out_valid/out_stall| pix_out_t (col, row, rgb, run_last)
//  cfg_     | cfg_we             | cfg_index, cfg_data
//
// the front takes one pixel at a time (ram read, window update, queue push) and stalls its input until the push
// an interior result takes the back end through pop, 9 taps, 20 divide steps and output
// a pixel that is border only takes pop and output, one with no result only the pop
// reset is synchronous, active low; line stores are not cleared
// the queue lets the front keep accepting while the back end works or is stalled, until the queue is full
module rgb_convolution_3x3 #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rc3_pkg::pix_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rc3_pkg::pix_out_t            out_data,
  input  logic                         cfg_we,
  input  logic [rc3_pkg::IDX_W-1:0]    cfg_index,
  input  logic [rc3_pkg::KROW_W-1:0]   cfg_data
);
  import rc3_pkg::*;

  geom_t  geom_r;
  kern_t  kern_r;
  logic   q_push, q_full, q_pop, q_valid;
  entry_t q_in, q_out;

  // configuration registers; the user must write them only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.image_width  <= DIM_W'(640);
      geom_r.image_height <= DIM_W'(480);
      kern_r.row_top      <= '0;
      kern_r.row_middle   <= KROW_W'(256);
      kern_r.row_bottom   <= '0;
      kern_r.divisor      <= DIV_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   geom_r.image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  geom_r.image_height <= cfg_data[DIM_W-1:0];
        REG_KERNEL_TOP:    kern_r.row_top      <= cfg_data;
        REG_KERNEL_MIDDLE: kern_r.row_middle   <= cfg_data;
        REG_KERNEL_BOTTOM: kern_r.row_bottom   <= cfg_data;
        REG_KERNEL_DIV:    kern_r.divisor      <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // front: positions, line stores and window, one transaction per pixel
  rc3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  // short queue decoupling the two halves
  rc3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  // back: filter arithmetic and result transactions
  rc3_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .kern      (kern_r),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/rc3_ram.sv =====
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module rc3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rc3_queue.sv =====
`timescale 1ns / 1ps
// two entry queue between front and back
// depends on rc3_pkg
module rc3_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rc3_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output rc3_pkg::entry_t pop_data
);
  import rc3_pkg::*;

  entry_t     slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign valid    = (cnt_r != 2'd0);
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== hdl/rc3_front.sv =====
`timescale 1ns / 1ps
// front end: position tracking, line stores, window and classification
// depends on rc3_pkg, rc3_ram
module rc3_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rc3_pkg::geom_t   geom,
  input  logic             in_valid,
  output logic             in_stall,
  input  rc3_pkg::pix_in_t in_data,
  output logic             q_push,
  output rc3_pkg::entry_t  q_data,
  input  logic             q_full
);
  import rc3_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned WX = XW + 1;
  localparam int unsigned WY = YW + 1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD   = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       st_r, st_nxt;
  logic [XW-1:0]    col_r, col_nxt;
  logic [YW-1:0]    row_r, row_nxt;
  logic [WX-1:0]    x_r;
  logic [WY-1:0]    y_r;
  logic [PIX_W-1:0] px_r;
  logic             tiny_r, int_r, bord_r;
  win_t             win_r;

  logic [WX-1:0]    w, x0, x1, xn;
  logic [WY-1:0]    h, y0, y1, yn;
  logic             tiny, accept;
  logic [PIX_W-1:0] top_rd, mid_rd;

  assign accept   = in_valid && (st_r == F_IDLE);
  assign in_stall = (st_r != F_IDLE);

  always_comb begin
    w = ({20'd0, geom.image_width} > 32'(MAX_WIDTH)) ? WX'(MAX_WIDTH)
                                                     : WX'(geom.image_width);
    h = ({20'd0, geom.image_height} > 32'(MAX_HEIGHT)) ? WY'(MAX_HEIGHT)
                                                       : WY'(geom.image_height);
    tiny = (w < WX'(3)) || (h < WY'(3));
    x0 = in_data.frame_start ? '0 : {1'b0, col_r};
    y0 = in_data.frame_start ? '0 : {1'b0, row_r};
    x1 = x0;
    y1 = y0;
    if (!tiny) begin
      // counters left beyond a shrunken frame wrap to the next row
      if (x0 >= w) begin
        x1 = '0;
        y1 = y0 + WY'(1);
      end
      if (y1 >= h) begin
        y1 = '0;
      end
    end
    xn = x1 + WX'(1);
    yn = y1;
    if (xn >= w) begin
      xn = '0;
      yn = y1 + WY'(1);
    end
    if (yn >= h) begin
      yn = '0;
    end
    col_nxt = accept ? XW'(xn) : col_r;
    row_nxt = accept ? YW'(yn) : row_r;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE:  if (accept) st_nxt = F_RD;
      F_RD:    st_nxt = F_PUSH;
      F_PUSH:  if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  // row above in store a, two rows above in store b
  rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    ((st_r == F_RD) && !tiny_r),
    .waddr (XW'(x_r)),
    .wdata (px_r),
    .raddr (XW'(x1)),
    .rdata (mid_rd)
  );

  rc3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    ((st_r == F_RD) && !tiny_r),
    .waddr (XW'(x_r)),
    .wdata (mid_rd),
    .raddr (XW'(x1)),
    .rdata (top_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      col_r <= '0;
      row_r <= '0;
      win_r <= '0;
    end else begin
      st_r  <= st_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      if ((st_r == F_RD) && !tiny_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= top_rd;
        win_r[3] <= win_r[4];
        win_r[4] <= win_r[5];
        win_r[5] <= mid_rd;
        win_r[6] <= win_r[7];
        win_r[7] <= win_r[8];
        win_r[8] <= px_r;
      end
    end
    if (accept) begin
      x_r    <= x1;
      y_r    <= y1;
      px_r   <= {in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red};
      tiny_r <= tiny;
      int_r  <= !tiny && (x1 >= WX'(2)) && (y1 >= WY'(2));
      bord_r <= tiny || (x1 == '0) || (y1 == '0) || (x1 == w - WX'(1)) ||
                (y1 == h - WY'(1));
    end
  end

  assign q_push        = (st_r == F_PUSH) && !q_full;
  assign q_data.int_v  = int_r;
  assign q_data.bord_v = bord_r;
  assign q_data.x      = COORD_W'(x_r);
  assign q_data.y      = COORD_W'(y_r);
  assign q_data.px     = px_r;
  assign q_data.win    = win_r;

endmodule

// ===== hdl/rc3_back.sv =====
`timescale 1ns / 1ps
// back end: tap by tap multiply accumulate, bit serial divide, clamp, output register
// depends on rc3_pkg
module rc3_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rc3_pkg::kern_t    kern,
  input  logic              q_valid,
  input  rc3_pkg::entry_t   q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output rc3_pkg::pix_out_t out_data
);
  import rc3_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_MAC   = 3'd1;
  localparam logic [2:0] B_DIV   = 3'd2;
  localparam logic [2:0] B_OINT  = 3'd3;
  localparam logic [2:0] B_OBORD = 3'd4;

  logic [2:0]              state_r, state_nxt;
  entry_t                  ent_r;
  logic [3:0]              tap_r;
  logic [1:0]              krow_r, kcol_r;
  logic [4:0]              step_r;
  logic signed [SUM_W-1:0] acc_r [3];
  logic signed [SUM_W-1:0] acc_nxt [3];
  logic [NUM_W-1:0]        num_r [3];
  logic [DIV_W-1:0]        rem_r [3];
  logic [NUM_W-1:0]        quo_r [3];
  logic [DIV_W-1:0]        dv_r;
  logic                    out_valid_r;
  pix_out_t                out_r;

  logic [PIX_W-1:0]        tap_px;
  logic [KROW_W-1:0]       row_bits;
  logic signed [7:0]       wt;
  logic signed [16:0]      prod [3];
  logic [DIV_W:0]          rem_sh [3];
  logic                    ge [3];
  logic [7:0]              res [3];
  logic                    out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == B_IDLE) && q_valid;

  always_comb begin
    tap_px = ent_r.win[tap_r];
    unique case (krow_r)
      2'd0:    row_bits = kern.row_top;
      2'd1:    row_bits = kern.row_middle;
      default: row_bits = kern.row_bottom;
    endcase
    wt = $signed(row_bits[8*kcol_r +: 8]);
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch]    = $signed({1'b0, tap_px[8*ch +: 8]}) * wt;
      acc_nxt[ch] = acc_r[ch] + SUM_W'(prod[ch]);
      rem_sh[ch]  = {rem_r[ch], num_r[ch][NUM_W-1]};
      ge[ch]      = rem_sh[ch] >= {1'b0, dv_r};
      res[ch]     = (|quo_r[ch][NUM_W-1:8]) ? 8'd255 : quo_r[ch][7:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        // a pixel that completes no window and is not on the border owes nothing
        if (q_valid) begin
          if (q_data.int_v) begin
            state_nxt = B_MAC;
          end else if (q_data.bord_v) begin
            state_nxt = B_OBORD;
          end
        end
      end
      B_MAC:   if (tap_r == 4'd8) state_nxt = B_DIV;
      B_DIV:   if (step_r == 5'(NUM_W - 1)) state_nxt = B_OINT;
      B_OINT:  if (out_free) state_nxt = ent_r.bord_v ? B_OBORD : B_IDLE;
      B_OBORD: if (out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (((state_r == B_OINT) || (state_r == B_OBORD)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      ent_r  <= q_data;
      tap_r  <= 4'd0;
      krow_r <= 2'd0;
      kcol_r <= 2'd0;
      for (int ch = 0; ch < 3; ch++) acc_r[ch] <= '0;
    end
    if (state_r == B_MAC) begin
      tap_r <= tap_r + 4'd1;
      if (kcol_r == 2'd2) begin
        kcol_r <= 2'd0;
        krow_r <= krow_r + 2'd1;
      end else begin
        kcol_r <= kcol_r + 2'd1;
      end
      for (int ch = 0; ch < 3; ch++) acc_r[ch] <= acc_nxt[ch];
      if (tap_r == 4'd8) begin
        // negative sums clamp to zero anyway, so only positive ones are divided
        step_r <= 5'd0;
        dv_r   <= (kern.divisor == '0) ? DIV_W'(1) : kern.divisor;
        for (int ch = 0; ch < 3; ch++) begin
          num_r[ch] <= (acc_nxt[ch] > 0) ? NUM_W'(acc_nxt[ch]) : '0;
          rem_r[ch] <= '0;
          quo_r[ch] <= '0;
        end
      end
    end
    if (state_r == B_DIV) begin
      step_r <= step_r + 5'd1;
      for (int ch = 0; ch < 3; ch++) begin
        num_r[ch] <= {num_r[ch][NUM_W-2:0], 1'b0};
        quo_r[ch] <= {quo_r[ch][NUM_W-2:0], ge[ch]};
        rem_r[ch] <= ge[ch] ? DIV_W'(rem_sh[ch] - {1'b0, dv_r}) : rem_sh[ch][DIV_W-1:0];
      end
    end
    if ((state_r == B_OINT) && out_free) begin
      out_r.out_col   <= ent_r.x - COORD_W'(1);
      out_r.out_row   <= ent_r.y - COORD_W'(1);
      out_r.out_red   <= res[0];
      out_r.out_green <= res[1];
      out_r.out_blue  <= res[2];
      out_r.run_last  <= !ent_r.bord_v;
    end
    if ((state_r == B_OBORD) && out_free) begin
      out_r.out_col   <= ent_r.x;
      out_r.out_row   <= ent_r.y;
      out_r.out_red   <= ent_r.px[7:0];
      out_r.out_green <= ent_r.px[15:8];
      out_r.out_blue  <= ent_r.px[23:16];
      out_r.run_last  <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |=> (state_r == B_DIV || state_r == B_OINT))
    else $error("divide left to an unexpected state");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE && q_valid))
    else $error("queue popped while busy");
`endif

endmodule
